>>> rtl/dhf_pkg.sv
// drive health failover package: field widths, codes and register reset values
package dhf_pkg;

    // input word fields
    localparam int unsigned AIDX_W   = 4;
    localparam int unsigned DIDX_W   = 5;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned NDEV_W   = 6;
    localparam int unsigned NSPARE_W = 4;
    localparam int unsigned SMART_W  = 16;
    localparam int unsigned IN_DATA_W  = 88;
    localparam int unsigned IN_USER_W  = 1;

    // output word fields
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned DSTATE_W = 3;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned SPARES_W = 4;
    localparam int unsigned OUT_DATA_W = 16;

    // counters
    localparam int unsigned CNT_W = 8;

    // apb
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned REG_IDX_W  = 3;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_REALLOC_FAIL    = 3'd0;
    localparam t_reg_idx REG_REALLOC_DEGRADE = 3'd1;
    localparam t_reg_idx REG_CRC_COUNT       = 3'd2;
    localparam t_reg_idx REG_CRC_DEGRADE     = 3'd3;
    localparam t_reg_idx REG_ERROR_FAIL      = 3'd4;
    localparam t_reg_idx REG_WARNING_DEGRADE = 3'd5;

    localparam logic [SMART_W-1:0] RST_REALLOC_FAIL    = 16'd100;
    localparam logic [SMART_W-1:0] RST_REALLOC_DEGRADE = 16'd10;
    localparam logic [SMART_W-1:0] RST_CRC_COUNT       = 16'd50;
    localparam logic [SMART_W-1:0] RST_CRC_DEGRADE     = 16'd100;
    localparam logic [CNT_W-1:0]   RST_ERROR_FAIL      = 8'd10;
    localparam logic [CNT_W-1:0]   RST_WARNING_DEGRADE = 8'd5;

    // commands
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_REPORT   = 1'b1;

    // array kinds
    localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;

    // result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_UNKNOWN      = 4'd0;
    localparam t_status ST_REGISTERED   = 4'd1;
    localparam t_status ST_FULL         = 4'd2;
    localparam t_status ST_NOCHANGE     = 4'd3;
    localparam t_status ST_FAIL_MANUAL  = 4'd4;
    localparam t_status ST_FAIL_NOSPARE = 4'd5;
    localparam t_status ST_REBUILD      = 4'd6;
    localparam t_status ST_REBUILD_FAIL = 4'd7;
    localparam t_status ST_DEGRADED     = 4'd8;
    localparam t_status ST_RECOVERED    = 4'd9;

    // drive states
    typedef logic [DSTATE_W-1:0] t_dstate;
    localparam t_dstate DS_HEALTHY  = 3'd0;
    localparam t_dstate DS_WARNING  = 3'd1;
    localparam t_dstate DS_DEGRADED = 3'd2;
    localparam t_dstate DS_FAILED   = 3'd3;
    localparam t_dstate DS_REPLACED = 3'd4;

    // one drive record in the health memory
    typedef struct packed {
        t_dstate           st;
        logic [CNT_W-1:0]  warn;
        logic [CNT_W-1:0]  err;
    } t_drv_rec;

endpackage

>>> rtl/drive_health_failover.sv
// drive health failover: per-drive health table with automatic rebuild on failure
//
//  channel | dir | handshake                | payload
//  s       | in  | i_s_tvalid / o_s_tready  | i_s_tdata (fields), i_s_tuser (cmd)
//  m       | out | o_m_tvalid / i_m_tready  | o_m_tdata (fields), o_m_tuser (status)
//  apb     | in  | psel, penable, pready    | paddr, pwrite, pwdata, prdata
//
// a report reads the drive and array memories at the accept edge; in S_EVAL it
// evaluates, writes the drive record back and loads the result.
// a register item that finds a free slot then zeroes, in S_CLEAR, each drive
// record of the new slot, one per cycle through the single drive memory port.
// reset only clears control state and array count and reloads the thresholds.
// a new word is taken while a result waits; evaluation holds until it drains.
module drive_health_failover #(
    parameter int unsigned ARRAY_SLOTS      = 16,
    parameter int unsigned DRIVES_PER_ARRAY = 32,
    parameter int unsigned SPARE_LIMIT      = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // array_index[3:0], drive_index[8:4], array_kind[10:9], device_count[16:11],
    // spare_count[20:17], rebuild_en[21], reallocated[37:22], pending[53:38],
    // uncorrectable[69:54], crc_count[85:70], replace_ok[86], zero[87]
    input  logic [dhf_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // cmd[0]
    input  logic [dhf_pkg::IN_USER_W-1:0]     i_s_tuser,
    // stream out
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // dstate[2:0], slot_index[6:3], kind_out[8:7], spares_left[12:9], zero[15:13]
    output logic [dhf_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // status[3:0]
    output logic [dhf_pkg::STATUS_W-1:0]      o_m_tuser,
    // apb configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dhf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dhf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dhf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import dhf_pkg::*;

    localparam int unsigned AW   = (ARRAY_SLOTS > 1) ? $clog2(ARRAY_SLOTS) : 1;
    localparam int unsigned DW   = (DRIVES_PER_ARRAY > 1) ? $clog2(DRIVES_PER_ARRAY) : 1;
    localparam int unsigned RW   = $clog2(ARRAY_SLOTS + 1);
    localparam int unsigned CW   = $clog2(DRIVES_PER_ARRAY + 1);
    localparam int unsigned SW   = $clog2(SPARE_LIMIT + 1);
    localparam int unsigned AXW  = (AW > AIDX_W) ? AW : AIDX_W;
    localparam int unsigned DXW  = (DW > DIDX_W) ? DW : DIDX_W;
    localparam int unsigned AREC_W = KIND_W + CW + SW + 1;
    localparam int unsigned DRV_DEPTH = ARRAY_SLOTS * (2 ** DW);
    localparam logic [DW-1:0] LAST_DRV = DW'(DRIVES_PER_ARRAY - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    // ---------------- configuration ----------------
    logic [SMART_W-1:0] r_realloc_fail, r_realloc_degrade, r_crc_count, r_crc_degrade;
    logic [CNT_W-1:0]   r_error_fail, r_warning_degrade;
    logic               cfg_we;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_realloc_fail    <= RST_REALLOC_FAIL;
            r_realloc_degrade <= RST_REALLOC_DEGRADE;
            r_crc_count       <= RST_CRC_COUNT;
            r_crc_degrade     <= RST_CRC_DEGRADE;
            r_error_fail      <= RST_ERROR_FAIL;
            r_warning_degrade <= RST_WARNING_DEGRADE;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_REALLOC_FAIL:    r_realloc_fail    <= pwdata[SMART_W-1:0];
                REG_REALLOC_DEGRADE: r_realloc_degrade <= pwdata[SMART_W-1:0];
                REG_CRC_COUNT:       r_crc_count       <= pwdata[SMART_W-1:0];
                REG_CRC_DEGRADE:     r_crc_degrade     <= pwdata[SMART_W-1:0];
                REG_ERROR_FAIL:      r_error_fail      <= pwdata[CNT_W-1:0];
                REG_WARNING_DEGRADE: r_warning_degrade <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_REALLOC_FAIL:    prdata = APB_DATA_W'(r_realloc_fail);
            REG_REALLOC_DEGRADE: prdata = APB_DATA_W'(r_realloc_degrade);
            REG_CRC_COUNT:       prdata = APB_DATA_W'(r_crc_count);
            REG_CRC_DEGRADE:     prdata = APB_DATA_W'(r_crc_degrade);
            REG_ERROR_FAIL:      prdata = APB_DATA_W'(r_error_fail);
            REG_WARNING_DEGRADE: prdata = APB_DATA_W'(r_warning_degrade);
            default:             prdata = '0;
        endcase
    end

    // ---------------- control registers ----------------
    logic [1:0]    r_state, n_state;
    logic [RW-1:0] r_count, n_count;
    logic [RW-1:0] r_slot, n_slot;
    logic [DW-1:0] r_clr, n_clr;
    logic          r_out_valid, n_out_valid;

    // captured input word
    logic                r_cmd;
    logic [AIDX_W-1:0]   r_aidx;
    logic [DIDX_W-1:0]   r_didx;
    logic [KIND_W-1:0]   r_kind;
    logic [NDEV_W-1:0]   r_ndev;
    logic [NSPARE_W-1:0] r_nspare;
    logic                r_auto;
    logic [SMART_W-1:0]  r_realloc, r_pend, r_uncorr, r_crc;
    logic                r_rep_ok;

    // result register
    t_status             r_out_st, n_out_st;
    t_dstate             r_out_ds, n_out_ds;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [KIND_W-1:0]   r_out_kind, n_out_kind;
    logic [SPARES_W-1:0] r_out_sp, n_out_sp;

    logic in_acc, out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid & o_s_tready;
    assign out_free   = ~r_out_valid | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= i_s_tuser[0];
            r_aidx    <= i_s_tdata[3:0];
            r_didx    <= i_s_tdata[8:4];
            r_kind    <= i_s_tdata[10:9];
            r_ndev    <= i_s_tdata[16:11];
            r_nspare  <= i_s_tdata[20:17];
            r_auto    <= i_s_tdata[21];
            r_realloc <= i_s_tdata[37:22];
            r_pend    <= i_s_tdata[53:38];
            r_uncorr  <= i_s_tdata[69:54];
            r_crc     <= i_s_tdata[85:70];
            r_rep_ok  <= i_s_tdata[86];
        end
    end

    // ---------------- memories ----------------
    t_drv_rec              mem_drv [DRV_DEPTH];
    logic [AREC_W-1:0]     mem_arr [ARRAY_SLOTS];
    t_drv_rec              r_drv_q;
    logic [AREC_W-1:0]     r_arr_q;

    logic                  drv_we, arr_we;
    logic [AW+DW-1:0]      drv_waddr, drv_raddr;
    t_drv_rec              drv_wdata;
    logic [AW-1:0]         arr_waddr, arr_raddr;
    logic [AREC_W-1:0]     arr_wdata;

    logic [AXW-1:0] in_aidx_x;
    logic [DXW-1:0] in_didx_x, r_didx_x;
    logic [AXW-1:0] r_aidx_x;

    assign in_aidx_x = AXW'(i_s_tdata[3:0]);
    assign in_didx_x = DXW'(i_s_tdata[8:4]);
    assign r_aidx_x  = AXW'(r_aidx);
    assign r_didx_x  = DXW'(r_didx);
    assign drv_raddr = {in_aidx_x[AW-1:0], in_didx_x[DW-1:0]};
    assign arr_raddr = in_aidx_x[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (drv_we) mem_drv[drv_waddr] <= drv_wdata;
        if (in_acc) r_drv_q <= mem_drv[drv_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (arr_we) mem_arr[arr_waddr] <= arr_wdata;
        if (in_acc) r_arr_q <= mem_arr[arr_raddr];
    end

    // ---------------- evaluation ----------------
    logic [KIND_W-1:0] a_kind;
    logic [CW-1:0]     a_cnt;
    logic [SW-1:0]     a_spare;
    logic              a_auto;

    assign {a_kind, a_cnt, a_spare, a_auto} = r_arr_q;

    // clamped register fields
    logic [CW-1:0] reg_cnt;
    logic [SW-1:0] reg_spare;
    assign reg_cnt   = (32'(r_ndev) > DRIVES_PER_ARRAY) ? CW'(DRIVES_PER_ARRAY) : CW'(r_ndev);
    assign reg_spare = (32'(r_nspare) > SPARE_LIMIT) ? SW'(SPARE_LIMIT) : SW'(r_nspare);

    logic             full, bad_array, bad_drive;
    logic             w_inc, e_inc, failed, degraded;
    logic [CNT_W-1:0] warn_n, err_n;
    t_dstate          ds_n;
    t_status          st_n;
    logic [SW-1:0]    spare_n;

    assign full      = (32'(r_count) >= ARRAY_SLOTS);
    assign bad_array = (32'(r_aidx) >= 32'(r_count)) || (32'(r_aidx) >= ARRAY_SLOTS);
    assign bad_drive = (32'(r_didx) >= 32'(a_cnt));

    assign w_inc  = (r_realloc != '0) || (r_pend != '0);
    assign e_inc  = (r_uncorr != '0) || (r_crc > r_crc_count);
    assign warn_n = (w_inc && r_drv_q.warn != '1) ? r_drv_q.warn + 1'b1 : r_drv_q.warn;
    assign err_n  = (e_inc && r_drv_q.err != '1) ? r_drv_q.err + 1'b1 : r_drv_q.err;

    assign failed   = (r_uncorr != '0) || (r_realloc > r_realloc_fail) ||
                      (err_n > r_error_fail);
    assign degraded = (r_realloc > r_realloc_degrade) || (r_pend != '0) ||
                      (r_crc > r_crc_degrade) || (warn_n > r_warning_degrade);

    always_comb begin
        ds_n    = r_drv_q.st;
        st_n    = ST_NOCHANGE;
        spare_n = a_spare;
        priority if (failed) begin
            if (r_drv_q.st != DS_FAILED && r_drv_q.st != DS_REPLACED) begin
                ds_n = DS_FAILED;
                priority if (!a_auto) begin
                    st_n = ST_FAIL_MANUAL;
                end else if (a_spare == '0) begin
                    st_n = ST_FAIL_NOSPARE;
                end else if (a_kind == KIND_UNDEF || !r_rep_ok) begin
                    st_n = ST_REBUILD_FAIL;
                end else begin
                    ds_n    = DS_REPLACED;
                    spare_n = a_spare - 1'b1;
                    st_n    = ST_REBUILD;
                end
            end
        end else if (degraded) begin
            if (r_drv_q.st < DS_DEGRADED) begin
                ds_n = DS_DEGRADED;
                st_n = ST_DEGRADED;
            end
        end else if (r_drv_q.st != DS_HEALTHY) begin
            if (warn_n == '0 && err_n == '0) begin
                ds_n = DS_HEALTHY;
                st_n = ST_RECOVERED;
            end
        end
    end

    // ---------------- sequencer ----------------
    logic [AXW-1:0] slot_x;
    assign slot_x = AXW'(r_slot);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_slot      = r_slot;
        n_clr       = r_clr;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_st    = r_out_st;
        n_out_ds    = r_out_ds;
        n_out_slot  = r_out_slot;
        n_out_kind  = r_out_kind;
        n_out_sp    = r_out_sp;
        drv_we      = 1'b0;
        drv_waddr   = {r_aidx_x[AW-1:0], r_didx_x[DW-1:0]};
        drv_wdata   = '{st: ds_n, warn: warn_n, err: err_n};
        arr_we      = 1'b0;
        arr_waddr   = r_aidx_x[AW-1:0];
        arr_wdata   = {a_kind, a_cnt, spare_n, a_auto};

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_cmd == CMD_REGISTER) begin
                    priority if (full) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_st    = ST_FULL;
                            n_out_ds    = DS_HEALTHY;
                            n_out_slot  = '0;
                            n_out_kind  = '0;
                            n_out_sp    = '0;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        arr_we    = 1'b1;
                        arr_waddr = AW'(r_count);
                        arr_wdata = {r_kind, reg_cnt, reg_spare, r_auto};
                        n_slot    = r_count;
                        n_count   = r_count + 1'b1;
                        n_clr     = '0;
                        n_state   = S_CLEAR;
                    end
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = r_aidx;
                    n_state     = S_IDLE;
                    priority if (bad_array) begin
                        n_out_st   = ST_UNKNOWN;
                        n_out_ds   = DS_HEALTHY;
                        n_out_kind = '0;
                        n_out_sp   = '0;
                    end else if (bad_drive) begin
                        n_out_st   = ST_UNKNOWN;
                        n_out_ds   = DS_HEALTHY;
                        n_out_kind = a_kind;
                        n_out_sp   = SPARES_W'(a_spare);
                    end else begin
                        drv_we     = 1'b1;
                        arr_we     = 1'b1;
                        n_out_st   = st_n;
                        n_out_ds   = ds_n;
                        n_out_kind = a_kind;
                        n_out_sp   = SPARES_W'(spare_n);
                    end
                end
            end
            S_CLEAR: begin
                // zero the new slot's drive records, one per cycle
                drv_we    = 1'b1;
                drv_waddr = {slot_x[AW-1:0], r_clr};
                drv_wdata = '{st: DS_HEALTHY, warn: '0, err: '0};
                if (r_clr != LAST_DRV) begin
                    n_clr = r_clr + 1'b1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = ST_REGISTERED;
                    n_out_ds    = DS_HEALTHY;
                    n_out_slot  = SLOT_W'(r_slot);
                    n_out_kind  = r_kind;
                    n_out_sp    = SPARES_W'(reg_spare);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_clr      <= n_clr;
        r_out_st   <= n_out_st;
        r_out_ds   <= n_out_ds;
        r_out_slot <= n_out_slot;
        r_out_kind <= n_out_kind;
        r_out_sp   <= n_out_sp;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_st;
    assign o_m_tdata  = {3'b000, r_out_sp, r_out_kind, r_out_slot, r_out_ds};

endmodule
